// File: rtl/smh_pkg.sv
// ============================================================================
// smh_pkg
// Shared types and constants of the string hash bucket block: controller
// states, datapath commands, status and configuration register indexes.
// ============================================================================
package smh_pkg;

    localparam int HASH_W     = 64;
    localparam int HALF_W     = 32;
    localparam int BYTE_W     = 8;
    localparam int BUCKET_W   = 16;
    localparam int SHSEL_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int ROUNDS     = 3;
    localparam int SHIFT_STEP = 16;
    localparam int DIV_STEPS  = HASH_W;
    localparam int ROUND_W    = 2;
    localparam int DIVCNT_W   = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MULT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MULT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_MULT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_SELECT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_XOR,
        ST_MUL_LL,
        ST_MUL_LH,
        ST_MUL_HL,
        ST_MUL_END,
        ST_ADD,
        ST_DIV,
        ST_PUSH
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_XOR,
        OP_MUL_LL,
        OP_MUL_LH,
        OP_MUL_HL,
        OP_MUL_END,
        OP_ADD,
        OP_DIV_STEP,
        OP_PUSH
    } dp_op_t;

    typedef struct packed {
        dp_op_t              op;
        logic [ROUND_W-1:0]  round;
    } cmd_t;

    typedef struct packed {
        logic last;
        logic out_busy;
    } status_t;

    // Right shift of one xorshift round: 1, 17, 33 or 49.
    function automatic logic [5:0] shift_amount(input logic [1:0] field);
        logic [5:0] amt;
        amt = 6'(1 + SHIFT_STEP * int'(field));
        return amt;
    endfunction

endpackage

// File: rtl/smh_ctrl.sv
// ============================================================================
// smh_ctrl
// Sequencer of the hash block: walks each byte through three xorshift and
// multiply rounds, the byte add and, at a word end, the bucket remainder.
// ============================================================================
module smh_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output smh_pkg::cmd_t   cmd,
    input  smh_pkg::status_t status
);

    smh_pkg::state_t                 state_reg, state_next;
    logic [smh_pkg::ROUND_W-1:0]     round_reg, round_next;
    logic [smh_pkg::DIVCNT_W-1:0]    div_cnt_reg, div_cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= smh_pkg::ST_IDLE;
            round_reg   <= '0;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            round_reg   <= round_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        round_next   = round_reg;
        div_cnt_next = div_cnt_reg;
        s_ready      = 1'b0;
        cmd.op       = smh_pkg::OP_NONE;
        cmd.round    = round_reg;
        unique case (state_reg)
            smh_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = smh_pkg::OP_LOAD;
                    round_next = '0;
                    state_next = smh_pkg::ST_XOR;
                end
            end
            smh_pkg::ST_XOR: begin
                cmd.op     = smh_pkg::OP_XOR;
                state_next = smh_pkg::ST_MUL_LL;
            end
            smh_pkg::ST_MUL_LL: begin
                cmd.op     = smh_pkg::OP_MUL_LL;
                state_next = smh_pkg::ST_MUL_LH;
            end
            smh_pkg::ST_MUL_LH: begin
                cmd.op     = smh_pkg::OP_MUL_LH;
                state_next = smh_pkg::ST_MUL_HL;
            end
            smh_pkg::ST_MUL_HL: begin
                cmd.op     = smh_pkg::OP_MUL_HL;
                state_next = smh_pkg::ST_MUL_END;
            end
            smh_pkg::ST_MUL_END: begin
                cmd.op = smh_pkg::OP_MUL_END;
                if (round_reg == smh_pkg::ROUND_W'(smh_pkg::ROUNDS - 1)) begin
                    state_next = smh_pkg::ST_ADD;
                end else begin
                    round_next = round_reg + 1'b1;
                    state_next = smh_pkg::ST_XOR;
                end
            end
            smh_pkg::ST_ADD: begin
                cmd.op       = smh_pkg::OP_ADD;
                div_cnt_next = '0;
                state_next   = status.last ? smh_pkg::ST_DIV : smh_pkg::ST_IDLE;
            end
            smh_pkg::ST_DIV: begin
                cmd.op       = smh_pkg::OP_DIV_STEP;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == smh_pkg::DIVCNT_W'(smh_pkg::DIV_STEPS - 1)) begin
                    state_next = smh_pkg::ST_PUSH;
                end
            end
            smh_pkg::ST_PUSH: begin
                // Wait here while the previous result is still held downstream.
                if (!status.out_busy) begin
                    cmd.op     = smh_pkg::OP_PUSH;
                    state_next = smh_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = smh_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/smh_dp.sv
// ============================================================================
// smh_dp
// Datapath of the hash block: configuration registers, running hash, shared
// 32x32 multiplier, restoring remainder unit and the output register.
// ============================================================================
module smh_dp (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [smh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [smh_pkg::HASH_W-1:0]        cfg_wr_data,
    input  logic [smh_pkg::BYTE_W-1:0]        s_char_byte,
    input  logic                              s_word_end,
    input  smh_pkg::cmd_t                     cmd,
    output smh_pkg::status_t                  status,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [smh_pkg::HASH_W-1:0]        m_hash_value,
    output logic [smh_pkg::BUCKET_W-1:0]      m_bucket_index
);

    localparam int HW = smh_pkg::HASH_W;
    localparam int LW = smh_pkg::HALF_W;
    localparam int BW = smh_pkg::BUCKET_W;

    // Configuration.
    logic [HW-1:0]               start_reg;
    logic [HW-1:0]               mult_reg [smh_pkg::ROUNDS];
    logic [smh_pkg::SHSEL_W-1:0] shsel_reg;
    logic [BW-1:0]               bucket_reg;

    // Working state.
    logic [HW-1:0]               hash_reg;
    logic [HW-1:0]               acc_reg;
    logic [HW-1:0]               prod_reg;
    logic [smh_pkg::BYTE_W-1:0]  byte_reg;
    logic                        last_reg;
    logic                        word_open_reg;
    logic [HW-1:0]               dvd_reg;
    logic [BW-1:0]               rem_reg;
    logic                        m_valid_reg;
    logic [HW-1:0]               m_hash_reg;
    logic [BW-1:0]               m_bucket_reg;

    logic [HW-1:0]               mult_cur;
    logic [1:0]                  shift_field;
    logic [5:0]                  shift_amt;
    logic [LW-1:0]               mul_a, mul_b;
    logic [HW-1:0]               mul_out;
    logic [HW-1:0]               sum;
    logic [BW:0]                 trial;
    logic [BW-1:0]               trial_diff;
    logic                        push;

    assign mult_cur    = mult_reg[cmd.round];
    assign shift_field = shsel_reg[{cmd.round, 1'b0} +: 2];
    assign shift_amt   = smh_pkg::shift_amount(shift_field);
    assign sum         = hash_reg + {{(HW - smh_pkg::BYTE_W){1'b0}}, byte_reg};
    assign trial       = {rem_reg, dvd_reg[HW-1]};
    assign trial_diff  = BW'(trial - {1'b0, bucket_reg});
    assign push        = (cmd.op == smh_pkg::OP_PUSH);

    // Operand select for the single shared multiplier. Only the low half of
    // the cross products is kept, which is all a product modulo 2^64 needs.
    always_comb begin
        mul_a = hash_reg[LW-1:0];
        mul_b = mult_cur[LW-1:0];
        case (cmd.op)
            smh_pkg::OP_MUL_LH: begin
                mul_a = hash_reg[LW-1:0];
                mul_b = mult_cur[HW-1:LW];
            end
            smh_pkg::OP_MUL_HL: begin
                mul_a = hash_reg[HW-1:LW];
                mul_b = mult_cur[LW-1:0];
            end
            default: begin
                mul_a = hash_reg[LW-1:0];
                mul_b = mult_cur[LW-1:0];
            end
        endcase
    end

    assign mul_out = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= '0;
            mult_reg[0] <= HW'(1);
            mult_reg[1] <= HW'(1);
            mult_reg[2] <= HW'(1);
            shsel_reg   <= '0;
            bucket_reg  <= BW'(2048);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                smh_pkg::CFG_START_VALUE:  start_reg   <= cfg_wr_data;
                smh_pkg::CFG_FIRST_MULT:   mult_reg[0] <= cfg_wr_data;
                smh_pkg::CFG_SECOND_MULT:  mult_reg[1] <= cfg_wr_data;
                smh_pkg::CFG_THIRD_MULT:   mult_reg[2] <= cfg_wr_data;
                smh_pkg::CFG_SHIFT_SELECT: shsel_reg   <= cfg_wr_data[smh_pkg::SHSEL_W-1:0];
                smh_pkg::CFG_BUCKET_COUNT: bucket_reg  <= cfg_wr_data[BW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_open_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.op == smh_pkg::OP_LOAD) begin
                word_open_reg <= 1'b1;
            end else if (cmd.op == smh_pkg::OP_ADD && last_reg) begin
                word_open_reg <= 1'b0;
            end
            if (push) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            smh_pkg::OP_LOAD: begin
                byte_reg <= s_char_byte;
                last_reg <= s_word_end;
                if (!word_open_reg) begin
                    hash_reg <= start_reg;
                end
            end
            smh_pkg::OP_XOR: begin
                hash_reg <= hash_reg ^ (hash_reg >> shift_amt);
            end
            smh_pkg::OP_MUL_LL: begin
                prod_reg <= mul_out;
            end
            smh_pkg::OP_MUL_LH: begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_out;
            end
            smh_pkg::OP_MUL_HL: begin
                acc_reg[HW-1:LW] <= acc_reg[HW-1:LW] + prod_reg[LW-1:0];
                prod_reg         <= mul_out;
            end
            smh_pkg::OP_MUL_END: begin
                hash_reg <= {acc_reg[HW-1:LW] + prod_reg[LW-1:0], acc_reg[LW-1:0]};
            end
            smh_pkg::OP_ADD: begin
                hash_reg <= sum;
                dvd_reg  <= sum;
                rem_reg  <= '0;
            end
            smh_pkg::OP_DIV_STEP: begin
                // One restoring step: bring in the next dividend bit.
                if (trial >= {1'b0, bucket_reg}) begin
                    rem_reg <= trial_diff;
                end else begin
                    rem_reg <= trial[BW-1:0];
                end
                dvd_reg <= {dvd_reg[HW-2:0], 1'b0};
            end
            smh_pkg::OP_PUSH: begin
                m_hash_reg   <= hash_reg;
                m_bucket_reg <= (bucket_reg == '0) ? '0 : rem_reg;
            end
            default: begin
            end
        endcase
    end

    assign status.last     = last_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

    assign m_valid        = m_valid_reg;
    assign m_hash_value   = m_hash_reg;
    assign m_bucket_index = m_bucket_reg;

endmodule

// File: rtl/string_mix_hash_bucket.sv
// ============================================================================
// string_mix_hash_bucket
// Running 64-bit string hash with three xorshift-multiply rounds per byte and
// a bucket index taken as the hash modulo a configured bucket count.
// ============================================================================
// Usage:
//   Bytes of a word arrive on the s_ channel, one request each; s_word_end
//   marks the last byte. The first byte of a word starts from start_value.
//   A word end produces one request on the m_ channel with the hash and the
//   bucket index; other bytes produce nothing.
//   While a byte is in work, s_ready stays low: one 32x32 multiplier is shared
//   by the three 64-bit products (three partial products each), and the byte
//   add follows the third round. A word end then runs a bit-serial remainder
//   unit over the 64-bit hash and loads the output register, raising m_valid.
//   The output register holds a result until it is taken; the next word's
//   bytes are accepted meanwhile. If a new result is ready while the old one
//   is still stalled, the block waits with s_ready low. Configuration is
//   written through cfg_wr_en, cfg_index and cfg_wr_data; the user must write
//   it only while the block is idle, which the block does not enforce. aresetn
//   is synchronous and active low; it empties the output register, closes any
//   open word and restores register defaults.
// ============================================================================
module string_mix_hash_bucket (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [smh_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [smh_pkg::HASH_W-1:0]        cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [smh_pkg::BYTE_W-1:0]        s_char_byte,
    input  logic                              s_word_end,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [smh_pkg::HASH_W-1:0]        m_hash_value,
    output logic [smh_pkg::BUCKET_W-1:0]      m_bucket_index
);

    smh_pkg::cmd_t    cmd;
    smh_pkg::status_t status;

    smh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .status  (status)
    );

    smh_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_char_byte    (s_char_byte),
        .s_word_end     (s_word_end),
        .cmd            (cmd),
        .status         (status),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_hash_value   (m_hash_value),
        .m_bucket_index (m_bucket_index)
    );

endmodule

// File: rtl/smh_checker.sv
// ============================================================================
// smh_checker
// Port-level checks of the hash block, attached to the top level by bind.
// ============================================================================
module smh_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic [smh_pkg::HASH_W-1:0]        m_hash_value,
    input  logic [smh_pkg::BUCKET_W-1:0]      m_bucket_index
);

    logic s_accept;

    assign s_accept = s_valid && s_ready;

    // A stalled result stays valid.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_hash_value) && $stable(m_bucket_index))
        else $error("result payload changed while stalled");

    // The block works on one byte at a time.
    a_one_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("byte accepted while another is in work");

    // A new result needs the full round and remainder sequence of a word end.
    a_result_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_accept, 1) && !$past(s_accept, 2))
        else $error("result appeared too soon after a byte");

endmodule

bind string_mix_hash_bucket smh_checker u_smh_checker (.*);
